FILE: rtl/chte_pkg.sv
package chte_pkg;

    // Table geometry
    localparam int NUM_BUCKETS = 256;
    localparam int NUM_CELLS   = 1024;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CELL_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int LINK_W = $clog2(NUM_CELLS + 1);

    // A link equal to the pool size marks the end of a chain
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_CELLS);

    // Operation codes carried on tuser
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_LOOKUP = 2'd1;
    localparam t_kind KIND_REMOVE = 2'd2;
    localparam t_kind KIND_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_HEAD_RD,
        ST_HEAD_LD,
        ST_WALK,
        ST_CMP,
        ST_REM,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [LINK_W-1:0] addr;
        logic              wr_kv;
        logic              wr_link;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [LINK_W-1:0] link;
    } t_cell_req;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [LINK_W-1:0] link;
    } t_cell_rsp;

    typedef struct packed {
        logic [BKT_W-1:0]  addr;
        logic              wr;
        logic [LINK_W-1:0] link;
    } t_head_req;

    typedef struct packed {
        logic             load;
        logic             ok;
        logic [VAL_W-1:0] value;
    } t_result;

endpackage

FILE: rtl/chte_heads.sv
module chte_heads
    import chte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_head_req         i_req,
    output logic [LINK_W-1:0] o_head
);

    logic [LINK_W-1:0]      r_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_valid;
    logic [LINK_W-1:0]      r_rd_data;
    logic                   r_rd_hit;

    // Write a head and read the addressed bucket
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.link;
        end
        r_rd_data <= r_mem[i_req.addr];
    end

    // Track written buckets; an unwritten one is an empty chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            r_rd_hit <= r_valid[i_req.addr];
            if (i_req.wr) begin
                r_valid[i_req.addr] <= 1'b1;
            end
        end
    end

    assign o_head = r_rd_hit ? r_rd_data : LINK_NULL;

endmodule

FILE: rtl/chte_cells.sv
module chte_cells
    import chte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_req i_req,
    output t_cell_rsp o_rsp
);

    logic [KEY_W-1:0]  r_key_mem  [NUM_CELLS];
    logic [VAL_W-1:0]  r_val_mem  [NUM_CELLS];
    logic [LINK_W-1:0] r_link_mem [NUM_CELLS];

    logic [CELL_W-1:0] idx;
    logic [KEY_W-1:0]  r_rd_key;
    logic [VAL_W-1:0]  r_rd_val;
    logic [LINK_W-1:0] r_rd_link;
    logic [LINK_W-1:0] r_rd_next;
    logic              r_rd_fresh;
    // Cells at or above this index were never handed out; their link is index + 1
    logic [LINK_W-1:0] r_fresh;

    assign idx = i_req.addr[CELL_W-1:0];

    // Write and read the cell arrays
    always_ff @(posedge i_clk) begin
        if (i_req.wr_kv) begin
            r_key_mem[idx] <= i_req.key;
            r_val_mem[idx] <= i_req.value;
        end
        if (i_req.wr_link) begin
            r_link_mem[idx] <= i_req.link;
        end
        r_rd_key  <= r_key_mem[idx];
        r_rd_val  <= r_val_mem[idx];
        r_rd_link <= r_link_mem[idx];
        r_rd_next <= i_req.addr + LINK_W'(1);
    end

    // Advance the fresh mark as untouched cells are taken in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= '0;
            r_rd_fresh <= 1'b1;
        end else begin
            r_rd_fresh <= (i_req.addr >= r_fresh);
            if (i_req.wr_kv && (i_req.addr == r_fresh)) begin
                r_fresh <= r_fresh + LINK_W'(1);
            end
        end
    end

    always_comb begin
        o_rsp.key   = r_rd_key;
        o_rsp.value = r_rd_val;
        o_rsp.link  = r_rd_fresh ? r_rd_next : r_rd_link;
    end

endmodule

FILE: rtl/chte_ctrl.sv
module chte_ctrl
    import chte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_kind             i_kind,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic              i_out_free,
    input  logic [LINK_W-1:0] i_head,
    input  t_cell_rsp         i_cell,
    output logic              o_idle,
    output t_cell_req         o_cell,
    output t_head_req         o_head,
    output t_result           o_result
);

    t_state            r_state, n_state;
    t_kind             r_kind, n_kind;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [LINK_W-1:0] r_free_head, n_free_head;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_steps, n_steps;
    logic              r_res_ok, n_res_ok;
    logic [VAL_W-1:0]  r_res_val, n_res_val;
    logic              key_match;

    // Shared key comparator for the chain walk
    assign key_match = (i_cell.key == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free_head <= '0;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_steps     <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_val     <= n_val;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_res_ok  <= n_res_ok;
        r_res_val <= n_res_val;
    end

    // Sequence one operation
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_key       = r_key;
        n_val       = r_val;
        n_free_head = r_free_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_res_ok    = r_res_ok;
        n_res_val   = r_res_val;

        o_cell.addr    = r_cur;
        o_cell.wr_kv   = 1'b0;
        o_cell.wr_link = 1'b0;
        o_cell.key     = r_key;
        o_cell.value   = r_val;
        o_cell.link    = r_free_head;

        // Bucket is the key modulo a power-of-two bucket count
        o_head.addr = r_key[BKT_W-1:0];
        o_head.wr   = 1'b0;
        o_head.link = r_free_head;

        o_result.load  = 1'b0;
        o_result.ok    = r_res_ok;
        o_result.value = r_res_val;

        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_kind    = i_kind;
                    n_key     = i_key;
                    n_val     = i_value;
                    n_res_ok  = 1'b0;
                    n_res_val = '0;
                    case (i_kind)
                        KIND_INSERT:              n_state = ST_INS_RD;
                        KIND_LOOKUP, KIND_REMOVE: n_state = ST_HEAD_RD;
                        default:                  n_state = ST_RESP;
                    endcase
                end
            end
            ST_INS_RD: begin
                // Read the free cell's link and the bucket head
                o_cell.addr = r_free_head;
                n_state = (r_free_head == LINK_NULL) ? ST_RESP : ST_INS_WR;
            end
            ST_INS_WR: begin
                // Fill the cell and push it onto its chain
                o_cell.addr    = r_free_head;
                o_cell.wr_kv   = 1'b1;
                o_cell.wr_link = 1'b1;
                o_cell.link    = i_head;
                o_head.wr      = 1'b1;
                o_head.link    = r_free_head;
                n_free_head    = i_cell.link;
                n_res_ok       = 1'b1;
                n_state        = ST_RESP;
            end
            ST_HEAD_RD: begin
                n_state = ST_HEAD_LD;
            end
            ST_HEAD_LD: begin
                n_cur   = i_head;
                n_prev  = LINK_NULL;
                n_steps = '0;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                // Stop at chain end or at the step bound, else fetch the current cell
                if ((r_cur == LINK_NULL) || (r_steps == LINK_W'(NUM_CELLS))) begin
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (key_match) begin
                    if (r_kind == KIND_LOOKUP) begin
                        n_res_ok  = 1'b1;
                        n_res_val = i_cell.value;
                        n_state   = ST_RESP;
                    end else begin
                        // Unlink the match from its predecessor or the head
                        if (r_prev == LINK_NULL) begin
                            o_head.wr   = 1'b1;
                            o_head.link = i_cell.link;
                        end else begin
                            o_cell.addr    = r_prev;
                            o_cell.wr_link = 1'b1;
                            o_cell.link    = i_cell.link;
                        end
                        n_state = ST_REM;
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = i_cell.link;
                    n_steps = r_steps + LINK_W'(1);
                    n_state = ST_WALK;
                end
            end
            ST_REM: begin
                // Return the cell to the free list
                o_cell.addr    = r_cur;
                o_cell.wr_link = 1'b1;
                o_cell.link    = r_free_head;
                n_free_head    = r_cur;
                n_res_ok       = 1'b1;
                n_state        = ST_RESP;
            end
            ST_RESP: begin
                if (i_out_free) begin
                    o_result.load = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

`ifndef SYNTHESIS
    a_insert_full_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_RD && r_free_head == LINK_NULL)
            |=> (r_state == ST_RESP && !r_res_ok))
        else $error("insert into an empty pool did not fail");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_accept) |=> (r_state != ST_IDLE))
        else $error("accepted item did not start an operation");

    a_resp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && i_out_free) |=> (r_state == ST_IDLE))
        else $error("result transfer did not return to idle");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= LINK_W'(NUM_CELLS))
        else $error("chain walk passed the pool size");

    a_remove_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REM) |=> (r_free_head == $past(r_cur)))
        else $error("removed cell not at free list head");
`endif

endmodule

FILE: rtl/chained_hash_table_engine_unit.sv
// Chained hash map over a pool of 1024 key/value cells in 256 buckets
// (bucket = key mod 256), with a free list threaded through the cell links.
// tuser on the input selects insert (0), lookup (1) or remove (2); code 3 does
// nothing and reports a miss. Every input transfer yields one output transfer:
// tuser = ok, tdata = the value found on a lookup hit, otherwise zero.
// Items are handled one at a time; the input is ready only while idle. An
// insert reads the free cell and the bucket head, then writes; a lookup or
// remove reads the bucket head and walks the chain up to the match (a miss
// walks the whole chain), and a remove then frees the matched cell. Each
// visited cell needs one registered read of the cell memory followed by one
// key compare. No clearing pass is needed after reset: bucket heads carry
// valid bits and untouched cells are tracked by a fill mark, so the block is
// ready as soon as reset is released.
module chained_hash_table_engine_unit
    import chte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] key, [63:32] value
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] found_value
    output logic        o_m_tuser    // [0] ok
);

    logic              idle;
    logic              accept;
    logic              out_free;
    t_cell_req         cell_req;
    t_cell_rsp         cell_rsp;
    t_head_req         head_req;
    logic [LINK_W-1:0] head;
    t_result           result;

    logic              r_m_valid;
    logic              r_m_ok;
    logic [VAL_W-1:0]  r_m_value;

    assign o_s_tready = idle;
    assign accept     = i_s_tvalid & idle;
    assign out_free   = ~r_m_valid | i_m_tready;

    chte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (i_s_tuser),
        .i_key      (i_s_tdata[KEY_W-1:0]),
        .i_value    (i_s_tdata[32 +: VAL_W]),
        .i_out_free (out_free),
        .i_head     (head),
        .i_cell     (cell_rsp),
        .o_idle     (idle),
        .o_cell     (cell_req),
        .o_head     (head_req),
        .o_result   (result)
    );

    chte_heads u_heads (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (head_req),
        .o_head  (head)
    );

    chte_cells u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cell_req),
        .o_rsp   (cell_rsp)
    );

    // Hold the result until the downstream transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (result.load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.load) begin
            r_m_ok    <= result.ok;
            r_m_value <= result.value;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_ok;
    assign o_m_tdata  = r_m_value;

endmodule

FILE: verif/chte_scoreboard_pkg.sv
package chte_scoreboard_pkg;

    import chte_pkg::*;

    // Mirror of the hash map state plus the queue of responses still owed
    class chte_scoreboard;

        typedef struct {
            logic        ok;
            logic [31:0] value;
        } t_outcome;

        logic [LINK_W-1:0] head_of   [NUM_BUCKETS];
        logic [KEY_W-1:0]  key_of    [NUM_CELLS];
        logic [VAL_W-1:0]  value_of  [NUM_CELLS];
        logic [LINK_W-1:0] next_of   [NUM_CELLS];
        logic [LINK_W-1:0] free_head;
        t_outcome          owed_q[$];
        int                errors;

        function new();
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                head_of[b] = LINK_NULL;
            end
            for (int c = 0; c < NUM_CELLS; c++) begin
                key_of[c]   = '0;
                value_of[c] = '0;
                next_of[c]  = LINK_W'(c + 1);
            end
            next_of[NUM_CELLS-1] = LINK_NULL;
            free_head = '0;
            errors    = 0;
        endfunction

        // Walk the bucket chain; return the first matching cell or null
        function logic [LINK_W-1:0] find_cell(logic [KEY_W-1:0] key,
                                              output logic [LINK_W-1:0] prev);
            logic [LINK_W-1:0] cur;
            int                steps;
            cur   = head_of[key % NUM_BUCKETS];
            prev  = LINK_NULL;
            steps = 0;
            while (cur < NUM_CELLS && steps < NUM_CELLS) begin
                if (key_of[cur] == key) begin
                    return cur;
                end
                prev = cur;
                cur  = next_of[cur];
                steps++;
            end
            prev = LINK_NULL;
            return LINK_NULL;
        endfunction

        // Apply one accepted request to the mirror and queue its response
        function void note_request(t_kind kind, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
            t_outcome          res;
            logic [LINK_W-1:0] cell_idx;
            logic [LINK_W-1:0] prev;
            int unsigned       bkt;
            res.ok    = 1'b0;
            res.value = '0;
            bkt       = key % NUM_BUCKETS;
            if (kind == KIND_INSERT) begin
                cell_idx = free_head;
                if (cell_idx < NUM_CELLS) begin
                    free_head          = next_of[cell_idx];
                    key_of[cell_idx]   = key;
                    value_of[cell_idx] = value;
                    next_of[cell_idx]  = head_of[bkt];
                    head_of[bkt]       = cell_idx;
                    res.ok             = 1'b1;
                end
            end else if (kind == KIND_LOOKUP) begin
                cell_idx = find_cell(key, prev);
                if (cell_idx < NUM_CELLS) begin
                    res.ok    = 1'b1;
                    res.value = value_of[cell_idx];
                end
            end else if (kind == KIND_REMOVE) begin
                cell_idx = find_cell(key, prev);
                if (cell_idx < NUM_CELLS) begin
                    if (prev < NUM_CELLS) begin
                        next_of[prev] = next_of[cell_idx];
                    end else begin
                        head_of[bkt] = next_of[cell_idx];
                    end
                    next_of[cell_idx] = free_head;
                    free_head         = cell_idx;
                    res.ok            = 1'b1;
                end
            end
            owed_q.push_back(res);
        endfunction

        // Compare one output transfer against the oldest owed response
        function void check_response(logic ok, logic [31:0] value);
            t_outcome exp_res;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected response ok=%0b value=%h", $time, ok, value);
                errors++;
                return;
            end
            exp_res = owed_q.pop_front();
            if (ok !== exp_res.ok) begin
                $display("%0t: ok mismatch expected %0b actual %0b",
                         $time, exp_res.ok, ok);
                errors++;
            end
            if (value !== exp_res.value) begin
                $display("%0t: found_value mismatch expected %h actual %h",
                         $time, exp_res.value, value);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

    endclass

endpackage

FILE: verif/chained_hash_table_engine_unit_tb.sv
module chained_hash_table_engine_unit_tb;

    import chte_pkg::*;
    import chte_scoreboard_pkg::*;

    localparam int KEY_POOL = 48;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [63:0] i_s_tdata  = '0;   // [31:0] key, [63:32] value
    logic [1:0]  i_s_tuser  = '0;   // [1:0] kind
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;         // [31:0] found_value
    logic        o_m_tuser;         // [0] ok

    chte_scoreboard sb = new();
    bit             idle_on = 1'b1;
    logic [31:0]    key_pool [KEY_POOL];

    chained_hash_table_engine_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Hang guard
    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Check every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_response(o_m_tuser, o_m_tdata);
        end
    end

    // Stall the result side in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_on && i_rst_n && $urandom_range(0, 9) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // Present one request, with an optional gap first, and hold until transfer
    task automatic send_request(t_kind kind, logic [31:0] key, logic [31:0] value);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 6) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {value, key};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        sb.note_request(kind, key, value);
    endtask

    task automatic refresh_key_pool();
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom;
        end
    endtask

    // Mostly keys that recur, some crowded into a few buckets, some fresh
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return key_pool[$urandom_range(0, KEY_POOL - 1)];
        if (r < 80) return ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 3);
        if (r < 82) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom;
    endfunction

    // Random mix; percentages for insert, lookup, remove, rest unused code
    task automatic run_mix(int count, int p_ins, int p_look, int p_rem);
        int    r;
        t_kind kind;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < p_ins) kind = KIND_INSERT;
            else if (r < p_ins + p_look) kind = KIND_LOOKUP;
            else if (r < p_ins + p_look + p_rem) kind = KIND_REMOVE;
            else kind = KIND_UNUSED;
            send_request(kind, pick_key(), $urandom);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes of key and value
        send_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        // Misses in an occupied bucket
        send_request(KIND_LOOKUP, 32'h0000_0100, 32'h0);
        send_request(KIND_REMOVE, 32'h0000_0100, 32'h0);
        // Duplicates: newest wins, older one shows again after removal
        send_request(KIND_INSERT, 32'h0000_0005, 32'hAAAA_5555);
        send_request(KIND_INSERT, 32'h0000_0005, 32'h5555_AAAA);
        send_request(KIND_LOOKUP, 32'h0000_0005, 32'h0);
        send_request(KIND_REMOVE, 32'h0000_0005, 32'h0);
        send_request(KIND_LOOKUP, 32'h0000_0005, 32'h0);
        send_request(KIND_REMOVE, 32'h0000_0005, 32'h0);
        send_request(KIND_LOOKUP, 32'h0000_0005, 32'h0);
        // Unlink from the middle and the tail of a chain
        send_request(KIND_INSERT, 32'h0000_0010, 32'h1111_0010);
        send_request(KIND_INSERT, 32'h0000_0110, 32'h1111_0110);
        send_request(KIND_INSERT, 32'h0000_0210, 32'h1111_0210);
        send_request(KIND_REMOVE, 32'h0000_0110, 32'h0);
        send_request(KIND_LOOKUP, 32'h0000_0210, 32'h0);
        send_request(KIND_LOOKUP, 32'h0000_0010, 32'h0);
        send_request(KIND_REMOVE, 32'h0000_0010, 32'h0);
        send_request(KIND_LOOKUP, 32'h0000_0110, 32'h0);
        // Unused operation code
        send_request(KIND_UNUSED, 32'h0000_0210, 32'hDEAD_BEEF);
        send_request(KIND_LOOKUP, 32'h0000_0210, 32'h0);

        // Balanced traffic
        refresh_key_pool();
        run_mix(500, 40, 35, 22);
        // Fill past the pool size so inserts run out of cells
        refresh_key_pool();
        run_mix(1150, 88, 6, 4);
        // Drain at full rate
        idle_on = 1'b0;
        run_mix(200, 10, 40, 48);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
